[rtl/ssmd_pkg.sv]
// Package for the multiplexed seven-segment display unit.
// Holds item and result types, constants and the segment decode table.
// No dependencies.
package ssmd_pkg;

  typedef logic [3:0]      digit_t;
  typedef logic [3:0][3:0] digits_t;

  typedef struct packed {
    logic        cmd;
    logic [13:0] value;
    logic [15:0] duration_ms;
    logic [2:0]  dot_pos;
  } item_t;

  typedef struct packed {
    logic [6:0]  segments;
    logic        dot;
    logic [3:0]  digit_enable;
    logic        error;
    logic        showing_number;
    logic [13:0] last_value;
    logic        has_value;
  } result_t;

  localparam logic        CmdTick      = 1'b0;
  localparam logic        CmdShow      = 1'b1;
  localparam logic [13:0] ValueMax     = 14'd9999;
  localparam logic [2:0]  NoDot        = 3'd4;
  localparam logic [6:0]  DashPattern  = 7'h40;
  localparam logic [19:0] LoopsMax     = 20'hFFFFF;
  localparam logic [15:0] IdleStepRst  = 16'd2000;
  localparam logic [4:0]  LoopsPerMsRst = 5'd2;

  // register indexes on the configuration port
  localparam logic RegIdleStepTicks = 1'b0;
  localparam logic RegLoopsPerMs    = 1'b1;

  function automatic logic [6:0] seg_pattern(input digit_t d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

[rtl/ssmd_digits.sv]
// Splits a value of up to 9999 into four decimal digits.
// Uses reciprocal multiplications in parallel; depends on ssmd_pkg.
module ssmd_digits (
  input  logic [13:0]       value_i,
  output ssmd_pkg::digits_t digits_o
);
  import ssmd_pkg::*;

  logic [29:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;
  logic [13:0] r0;
  logic [10:0] r1;
  logic [7:0]  r2;

  // v/10, v/100 and v/1000 each straight from the value
  assign p10   = 30'(value_i) * 30'd52429;
  assign p100  = 27'(value_i) * 27'd5243;
  assign p1000 = 28'(value_i) * 28'd8389;
  assign q10   = p10[29:19];
  assign q100  = p100[26:19];
  assign q1000 = p1000[27:23];

  assign r0 = value_i - (14'(q10) * 14'd10);
  assign r1 = q10 - (11'(q100) * 11'd10);
  assign r2 = q100 - (8'(q1000) * 8'd10);

  assign digits_o[0] = r0[3:0];
  assign digits_o[1] = r1[3:0];
  assign digits_o[2] = r2[3:0];
  assign digits_o[3] = q1000[3:0];

endmodule

[rtl/ssmd_engine.sv]
// Display state and the per-item update: show a number or run one refresh tick.
// Depends on ssmd_pkg and ssmd_digits.
module ssmd_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ssmd_pkg::item_t   item_i,
  input  logic [15:0]       idle_step_ticks_i,
  input  logic [4:0]        loops_per_ms_i,
  output ssmd_pkg::result_t result_o
);
  import ssmd_pkg::*;

  digits_t     digits;
  logic [20:0] loops_full;
  logic [19:0] loops;

  logic        number_mode_q, number_mode_d;
  digit_t      digit_store_q [4];
  logic [2:0]  dot_index_q, dot_index_d;
  logic [1:0]  scan_index_q, scan_index_d;
  logic [19:0] loops_left_q, loops_left_d;
  logic [15:0] idle_countdown_q, idle_countdown_d;
  logic [1:0]  idle_index_q, idle_index_d;
  logic [6:0]  drive_segments_q, drive_segments_d;
  logic        drive_dot_q, drive_dot_d;
  logic [3:0]  drive_digits_q, drive_digits_d;
  logic [13:0] saved_value_q, saved_value_d;
  logic        saved_valid_q, saved_valid_d;
  logic        store_digits;
  logic        error;

  ssmd_digits u_digits (
    .value_i  (item_i.value),
    .digits_o (digits)
  );

  assign loops_full = 21'(loops_per_ms_i) * 21'(item_i.duration_ms);
  assign loops      = loops_full[20] ? LoopsMax : loops_full[19:0];

  always_comb begin
    number_mode_d    = number_mode_q;
    dot_index_d      = dot_index_q;
    scan_index_d     = scan_index_q;
    loops_left_d     = loops_left_q;
    idle_countdown_d = idle_countdown_q;
    idle_index_d     = idle_index_q;
    drive_segments_d = drive_segments_q;
    drive_dot_d      = drive_dot_q;
    drive_digits_d   = drive_digits_q;
    saved_value_d    = saved_value_q;
    saved_valid_d    = saved_valid_q;
    store_digits     = 1'b0;
    error            = 1'b0;
    if (item_i.cmd == CmdShow) begin
      if (item_i.value > ValueMax) begin
        error = 1'b1;
      end else begin
        store_digits     = 1'b1;
        saved_value_d    = item_i.value;
        saved_valid_d    = 1'b1;
        dot_index_d      = item_i.dot_pos;
        scan_index_d     = 2'd0;
        loops_left_d     = loops;
        idle_countdown_d = 16'd0;
        idle_index_d     = 2'd0;
        number_mode_d    = (loops != 20'd0);
      end
    end else if (number_mode_q) begin
      drive_digits_d   = 4'b0001 << scan_index_q;
      drive_segments_d = seg_pattern(digit_store_q[scan_index_q]);
      drive_dot_d      = ({1'b0, scan_index_q} == dot_index_q);
      scan_index_d     = scan_index_q + 2'd1;
      loops_left_d     = loops_left_q - 20'd1;
      // last loop still drives its digit; idle starts on the next tick
      if (loops_left_d == 20'd0) begin
        number_mode_d    = 1'b0;
        idle_countdown_d = 16'd0;
        idle_index_d     = 2'd0;
      end
    end else if (idle_countdown_q == 16'd0) begin
      drive_digits_d   = 4'b1000 >> idle_index_q;
      drive_segments_d = DashPattern;
      drive_dot_d      = 1'b0;
      idle_index_d     = idle_index_q + 2'd1;
      idle_countdown_d = (idle_step_ticks_i == 16'd0) ? 16'd0 : idle_step_ticks_i - 16'd1;
    end else begin
      idle_countdown_d = idle_countdown_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_mode_q    <= 1'b0;
      dot_index_q      <= NoDot;
      scan_index_q     <= 2'd0;
      loops_left_q     <= 20'd0;
      idle_countdown_q <= 16'd0;
      idle_index_q     <= 2'd0;
      drive_segments_q <= 7'd0;
      drive_dot_q      <= 1'b0;
      drive_digits_q   <= 4'd0;
      saved_value_q    <= 14'd0;
      saved_valid_q    <= 1'b0;
    end else if (step_i) begin
      number_mode_q    <= number_mode_d;
      dot_index_q      <= dot_index_d;
      scan_index_q     <= scan_index_d;
      loops_left_q     <= loops_left_d;
      idle_countdown_q <= idle_countdown_d;
      idle_index_q     <= idle_index_d;
      drive_segments_q <= drive_segments_d;
      drive_dot_q      <= drive_dot_d;
      drive_digits_q   <= drive_digits_d;
      saved_value_q    <= saved_value_d;
      saved_valid_q    <= saved_valid_d;
    end
  end

  // digit store is always written before number mode reads it
  always_ff @(posedge clk_i) begin
    if (step_i && store_digits) begin
      for (int i = 0; i < 4; i++) begin
        digit_store_q[i] <= digits[i];
      end
    end
  end

  always_comb begin
    result_o.segments       = drive_segments_d;
    result_o.dot            = drive_dot_d;
    result_o.digit_enable   = drive_digits_d;
    result_o.error          = error;
    result_o.showing_number = number_mode_d;
    result_o.last_value     = saved_value_d;
    result_o.has_value      = saved_valid_d;
  end

endmodule

[rtl/seven_segment_mux_display_unit.sv]
// Four-digit multiplexed seven-segment driver: stream in, stream out, APB registers.
// Depends on ssmd_pkg and ssmd_engine.
//
// Each input item gives exactly one result item. An item with tuser = 1 shows a
// number (0..9999) for loops_per_ms * duration_ms refresh ticks; an item with
// tuser = 0 is one refresh tick that drives the next digit, right to left, or in
// idle mode steps a dash left to right every idle_step_ticks ticks. A value above
// 9999 returns error and changes nothing. The block takes one item per cycle while
// the result is not stalled. An accepted item is held in the input register until
// the result register is free; its result is then loaded there and m_axis_tvalid
// rises. The digit split and scan-length multiply sit between the two registers.
// A stalled result holds the input register and so s_axis_tready.
// Registers: 0x0 idle_step_ticks (16 bits), 0x4 loops_per_ms (5 bits);
// write them only while no item is in flight.
module seven_segment_mux_display_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[13:0], duration_ms[29:14], dot_pos[32:30]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // segments[6:0], dot[7], digit_enable[11:8],
                                     // error[12], showing_number[13],
                                     // last_value[27:14], has_value[28]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssmd_pkg::*;

  logic        in_valid_q;
  item_t       in_item_q;
  logic        out_valid_q;
  result_t     out_result_q;
  result_t     result;
  logic        advance;
  logic [15:0] idle_step_ticks_q;
  logic [4:0]  loops_per_ms_q;
  logic        cfg_write;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd         <= s_axis_tuser;
      in_item_q.value       <= s_axis_tdata[13:0];
      in_item_q.duration_ms <= s_axis_tdata[29:14];
      in_item_q.dot_pos     <= s_axis_tdata[32:30];
    end
    if (advance) begin
      out_result_q <= result;
    end
  end

  ssmd_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .item_i            (in_item_q),
    .idle_step_ticks_i (idle_step_ticks_q),
    .loops_per_ms_i    (loops_per_ms_q),
    .result_o          (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          out_result_q.has_value,
                          out_result_q.last_value,
                          out_result_q.showing_number,
                          out_result_q.error,
                          out_result_q.digit_enable,
                          out_result_q.dot,
                          out_result_q.segments};

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_step_ticks_q <= IdleStepRst;
      loops_per_ms_q    <= LoopsPerMsRst;
    end else if (cfg_write) begin
      case (paddr[2])
        RegIdleStepTicks: idle_step_ticks_q <= pwdata[15:0];
        RegLoopsPerMs:    loops_per_ms_q    <= pwdata[4:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegIdleStepTicks: prdata = {16'd0, idle_step_ticks_q};
      RegLoopsPerMs:    prdata = {27'd0, loops_per_ms_q};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
